[rtl/fsm_pkg.sv]
// ----------------------------------------------------------------------------
// fsm_pkg
// Shared types, constants and command codes of the focus sharpness metrics block.
// ----------------------------------------------------------------------------
package fsm_pkg;

    localparam int PIX_W     = 16;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;

    // Q0.16 luma weights, rounding half up
    localparam int LUMA_W = 33;
    localparam logic [LUMA_W-1:0] W_RED    = 33'd13933;
    localparam logic [LUMA_W-1:0] W_GREEN  = 33'd46871;
    localparam logic [LUMA_W-1:0] W_BLUE   = 33'd4732;
    localparam logic [LUMA_W-1:0] LUMA_RND = 33'd32768;

    localparam int LAP_W    = 19;
    localparam int LAP2_W   = 36;
    localparam int GRAD2_W  = 37;
    localparam int ROOT_W   = 19;
    localparam int SQ_IN_W  = 2 * ROOT_W;
    localparam int SQ_STEPS = ROOT_W;

    localparam int VAR_W = 36;
    localparam int TEN_W = 37;
    localparam int GM_W  = 19;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT    = 4'd1;
    localparam logic [OP_W-1:0] OP_LUMA      = 4'd2;
    localparam logic [OP_W-1:0] OP_WIN       = 4'd3;
    localparam logic [OP_W-1:0] OP_CALC      = 4'd4;
    localparam logic [OP_W-1:0] OP_SQ        = 4'd5;
    localparam logic [OP_W-1:0] OP_ACC       = 4'd6;
    localparam logic [OP_W-1:0] OP_SQRT      = 4'd7;
    localparam logic [OP_W-1:0] OP_ROOT      = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_LOAD  = 4'd9;
    localparam logic [OP_W-1:0] OP_MUL_STEP  = 4'd10;
    localparam logic [OP_W-1:0] OP_MUL_STORE = 4'd11;
    localparam logic [OP_W-1:0] OP_DIV_LOAD  = 4'd12;
    localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd13;
    localparam logic [OP_W-1:0] OP_DIV_STORE = 4'd14;
    localparam logic [OP_W-1:0] OP_EMIT      = 4'd15;

    localparam int SEL_W = 2;
    localparam logic [SEL_W-1:0] MSEL_N   = 2'd0;
    localparam logic [SEL_W-1:0] MSEL_NN  = 2'd1;
    localparam logic [SEL_W-1:0] MSEL_P1  = 2'd2;
    localparam logic [SEL_W-1:0] MSEL_P2  = 2'd3;
    localparam logic [SEL_W-1:0] DSEL_VAR = 2'd0;
    localparam logic [SEL_W-1:0] DSEL_TEN = 2'd1;
    localparam logic [SEL_W-1:0] DSEL_GM  = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [VAR_W-1:0] lap_variance;
        logic [TEN_W-1:0] tenengrad;
        logic [GM_W-1:0]  root_mean;
    } t_metrics;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SEL_W-1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_stat;

endpackage

[rtl/fsm_stream_if.sv]
// ----------------------------------------------------------------------------
// fsm_stream_if
// Valid/ready stream channel carrying one beat of payload.
// ----------------------------------------------------------------------------
interface fsm_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/fsm_ram.sv]
// ----------------------------------------------------------------------------
// fsm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/fsm_datapath.sv]
// ----------------------------------------------------------------------------
// fsm_datapath
// Luma, line stores, 3x3 window, gradient terms, sums, and the shared
// shift-add multiplier, restoring divider and square root units.
// ----------------------------------------------------------------------------
module fsm_datapath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fsm_pkg::t_cmd                i_cmd,
    output fsm_pkg::t_stat               o_stat,
    input  logic [fsm_pkg::CFG_W-1:0]    i_width,
    input  logic [fsm_pkg::CFG_W-1:0]    i_height,
    input  logic                         i_mode,
    input  fsm_pkg::t_pixel              i_pix,
    output logic                         o_out_valid,
    output fsm_pkg::t_metrics            o_out,
    input  logic                         i_out_ready
);
    localparam int PW     = fsm_pkg::PIX_W;
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int WW     = ($clog2(MAX_WIDTH + 1) > fsm_pkg::CFG_W) ?
                            $clog2(MAX_WIDTH + 1) : fsm_pkg::CFG_W;
    localparam int HW     = ($clog2(MAX_HEIGHT + 1) > fsm_pkg::CFG_W) ?
                            $clog2(MAX_HEIGHT + 1) : fsm_pkg::CFG_W;
    localparam int NB     = XW + YW;
    localparam int LT_W   = fsm_pkg::LAP_W + NB + 1;
    localparam int LSQ_W  = fsm_pkg::LAP2_W + NB + 1;
    localparam int GSQ_W  = fsm_pkg::GRAD2_W + NB + 1;
    localparam int RT_W   = fsm_pkg::ROOT_W + NB;
    localparam int MA_W   = LSQ_W;
    localparam int MB_W   = LT_W;
    localparam int MP_W   = MA_W + MB_W;
    localparam int NUM_W  = 2 * LT_W;
    localparam int DEN_W  = 2 * NB;
    localparam int CW     = fsm_pkg::LAP_W + 2;
    localparam int RW     = fsm_pkg::ROOT_W;
    localparam int SW     = fsm_pkg::SQ_IN_W;
    localparam int G1_W   = fsm_pkg::GRAD2_W - 1;

    // configuration, clamped
    logic [WW-1:0] w_c;
    logic [HW-1:0] h_c;

    always_comb begin
        if (WW'(i_width) < WW'(3)) begin
            w_c = WW'(3);
        end else if (WW'(i_width) > WW'(MAX_WIDTH)) begin
            w_c = WW'(MAX_WIDTH);
        end else begin
            w_c = WW'(i_width);
        end
        if (HW'(i_height) < HW'(3)) begin
            h_c = HW'(3);
        end else if (HW'(i_height) > HW'(MAX_HEIGHT)) begin
            h_c = HW'(MAX_HEIGHT);
        end else begin
            h_c = HW'(i_height);
        end
    end

    // pixel front end
    logic [PW-1:0] r_red, r_green, r_blue, r_cur;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic          r_interior, r_last;
    logic [PW-1:0] up_data, mid_data;
    logic [PW-1:0] r_win [9];
    logic [fsm_pkg::LUMA_W-1:0] luma_sum;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic          win_we, rd_en;

    assign rd_en  = (i_cmd.op == fsm_pkg::OP_ACCEPT);
    assign win_we = (i_cmd.op == fsm_pkg::OP_WIN);

    assign luma_sum = fsm_pkg::W_RED * fsm_pkg::LUMA_W'(r_red)
                    + fsm_pkg::W_GREEN * fsm_pkg::LUMA_W'(r_green)
                    + fsm_pkg::W_BLUE * fsm_pkg::LUMA_W'(r_blue)
                    + fsm_pkg::LUMA_RND;

    assign col_inc = WW'(r_col) + WW'(1);
    assign row_inc = HW'(r_row) + HW'(1);

    fsm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_col),
        .i_wdata (mid_data),
        .i_re    (rd_en),
        .i_raddr (r_col),
        .o_rdata (up_data)
    );

    fsm_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_col),
        .i_wdata (r_cur),
        .i_re    (rd_en),
        .i_raddr (r_col),
        .o_rdata (mid_data)
    );

    // window arithmetic
    logic signed [CW-1:0] e [9];
    logic signed [CW-1:0] lap_c, gx_c, gy_c;
    logic signed [fsm_pkg::LAP_W-1:0] r_lap, r_gx, r_gy;
    logic [fsm_pkg::LAP2_W-1:0] r_lap2;
    logic [G1_W-1:0] r_gx2, r_gy2;
    logic [fsm_pkg::GRAD2_W-1:0] g2;
    logic signed [2*fsm_pkg::LAP_W-1:0] lap_p, gx_p, gy_p;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            e[k] = $signed({{(CW - PW){1'b0}}, r_win[k]});
        end
        lap_c = (e[4] <<< 2) - e[3] - e[5] - e[1] - e[7];
        gx_c  = (e[2] + (e[5] <<< 1) + e[8]) - (e[0] + (e[3] <<< 1) + e[6]);
        gy_c  = (e[6] + (e[7] <<< 1) + e[8]) - (e[0] + (e[1] <<< 1) + e[2]);
    end

    assign lap_p = r_lap * r_lap;
    assign gx_p  = r_gx * r_gx;
    assign gy_p  = r_gy * r_gy;
    assign g2    = fsm_pkg::GRAD2_W'(r_gx2) + fsm_pkg::GRAD2_W'(r_gy2);

    // sums
    logic signed [LT_W-1:0] r_lt;
    logic [LSQ_W-1:0] r_lsq;
    logic [GSQ_W-1:0] r_gsq;
    logic [RT_W-1:0]  r_rt;
    logic [LT_W-1:0]  mag;

    assign mag = r_lt[LT_W-1] ? LT_W'(-r_lt) : LT_W'(r_lt);

    // square root unit
    logic [SW-1:0]   r_sv;
    logic [RW:0]     r_sr;
    logic [RW-1:0]   r_sq;
    logic [RW+2:0]   sq_t, sq_trial;
    logic            sq_ge;

    assign sq_t     = {r_sr, r_sv[SW-1 -: 2]};
    assign sq_trial = {1'b0, r_sq, 2'b01};
    assign sq_ge    = (sq_t >= sq_trial);

    // multiplier unit
    logic [MP_W-1:0]  r_ma, r_mp;
    logic [MB_W-1:0]  r_mb;
    logic [MA_W-1:0]  ma_sel;
    logic [MB_W-1:0]  mb_sel;
    logic [NB-1:0]    r_n;
    logic [DEN_W-1:0] r_nn;
    logic [NUM_W-1:0] r_p1, r_p2;

    always_comb begin
        case (i_cmd.sel)
            fsm_pkg::MSEL_N: begin
                ma_sel = MA_W'(w_c - WW'(2));
                mb_sel = MB_W'(h_c - HW'(2));
            end
            fsm_pkg::MSEL_NN: begin
                ma_sel = MA_W'(r_n);
                mb_sel = MB_W'(r_n);
            end
            fsm_pkg::MSEL_P1: begin
                ma_sel = MA_W'(r_lsq);
                mb_sel = MB_W'(r_n);
            end
            default: begin
                ma_sel = MA_W'(mag);
                mb_sel = mag;
            end
        endcase
    end

    // divider unit
    logic [NUM_W-1:0] r_dq, num_sel;
    logic [DEN_W-1:0] r_dr, r_dd, den_sel;
    logic [DEN_W:0]   dv_t;
    logic             dv_ge;

    assign dv_t  = {r_dr, r_dq[NUM_W-1]};
    assign dv_ge = (dv_t >= {1'b0, r_dd});

    always_comb begin
        case (i_cmd.sel)
            fsm_pkg::DSEL_VAR: begin
                num_sel = (r_p1 > r_p2) ? (r_p1 - r_p2) : '0;
                den_sel = r_nn;
            end
            fsm_pkg::DSEL_TEN: begin
                num_sel = NUM_W'(r_gsq);
                den_sel = DEN_W'(r_n);
            end
            default: begin
                num_sel = NUM_W'(r_rt);
                den_sel = DEN_W'(r_n);
            end
        endcase
    end

    // results
    logic [fsm_pkg::VAR_W-1:0] r_var;
    logic [fsm_pkg::TEN_W-1:0] r_ten;
    logic [fsm_pkg::GM_W-1:0]  r_gm;
    logic                      r_out_valid;
    fsm_pkg::t_metrics         r_out;

    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_last      <= 1'b0;
            r_interior  <= 1'b0;
            r_lt        <= '0;
            r_lsq       <= '0;
            r_gsq       <= '0;
            r_rt        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                fsm_pkg::OP_WIN: begin
                    r_interior <= (r_row >= YW'(2)) && (r_col >= XW'(2));
                    r_last     <= 1'b0;
                    if (col_inc >= w_c) begin
                        r_col <= '0;
                        if (row_inc >= h_c) begin
                            r_row  <= '0;
                            r_last <= 1'b1;
                        end else begin
                            r_row <= YW'(row_inc);
                        end
                    end else begin
                        r_col <= XW'(col_inc);
                    end
                end
                fsm_pkg::OP_ACC: begin
                    if (r_interior) begin
                        r_lt  <= r_lt + LT_W'(r_lap);
                        r_lsq <= r_lsq + LSQ_W'(r_lap2);
                        r_gsq <= r_gsq + GSQ_W'(g2);
                    end
                end
                fsm_pkg::OP_ROOT: begin
                    if (r_interior) begin
                        r_rt <= r_rt + RT_W'(r_sq);
                    end
                end
                fsm_pkg::OP_EMIT: begin
                    r_lt  <= '0;
                    r_lsq <= '0;
                    r_gsq <= '0;
                    r_rt  <= '0;
                end
                default: begin
                end
            endcase
            if (i_cmd.op == fsm_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            fsm_pkg::OP_ACCEPT: begin
                r_red   <= i_pix.red;
                r_green <= i_pix.green;
                r_blue  <= i_pix.blue;
            end
            fsm_pkg::OP_LUMA: begin
                r_cur <= i_mode ? luma_sum[2*PW-1:PW] : r_red;
            end
            fsm_pkg::OP_WIN: begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= up_data;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= mid_data;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_cur;
            end
            fsm_pkg::OP_CALC: begin
                r_lap <= fsm_pkg::LAP_W'(lap_c);
                r_gx  <= fsm_pkg::LAP_W'(gx_c);
                r_gy  <= fsm_pkg::LAP_W'(gy_c);
            end
            fsm_pkg::OP_SQ: begin
                r_lap2 <= fsm_pkg::LAP2_W'(lap_p);
                r_gx2  <= G1_W'(gx_p);
                r_gy2  <= G1_W'(gy_p);
            end
            fsm_pkg::OP_ACC: begin
                r_sv <= SW'(g2);
                r_sr <= '0;
                r_sq <= '0;
            end
            fsm_pkg::OP_SQRT: begin
                r_sv <= r_sv << 2;
                r_sr <= sq_ge ? (RW+1)'(sq_t - sq_trial) : (RW+1)'(sq_t);
                r_sq <= {r_sq[RW-2:0], sq_ge};
            end
            fsm_pkg::OP_MUL_LOAD: begin
                r_ma <= MP_W'(ma_sel);
                r_mb <= mb_sel;
                r_mp <= '0;
            end
            fsm_pkg::OP_MUL_STEP: begin
                if (r_mb[0]) begin
                    r_mp <= r_mp + r_ma;
                end
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end
            fsm_pkg::OP_MUL_STORE: begin
                case (i_cmd.sel)
                    fsm_pkg::MSEL_N:  r_n  <= r_mp[NB-1:0];
                    fsm_pkg::MSEL_NN: r_nn <= r_mp[DEN_W-1:0];
                    fsm_pkg::MSEL_P1: r_p1 <= r_mp[NUM_W-1:0];
                    default:          r_p2 <= r_mp[NUM_W-1:0];
                endcase
            end
            fsm_pkg::OP_DIV_LOAD: begin
                r_dq <= num_sel;
                r_dd <= den_sel;
                r_dr <= '0;
            end
            fsm_pkg::OP_DIV_STEP: begin
                r_dr <= dv_ge ? DEN_W'(dv_t - {1'b0, r_dd}) : DEN_W'(dv_t);
                r_dq <= {r_dq[NUM_W-2:0], dv_ge};
            end
            fsm_pkg::OP_DIV_STORE: begin
                case (i_cmd.sel)
                    fsm_pkg::DSEL_VAR: r_var <= r_dq[fsm_pkg::VAR_W-1:0];
                    fsm_pkg::DSEL_TEN: r_ten <= r_dq[fsm_pkg::TEN_W-1:0];
                    default:           r_gm  <= r_dq[fsm_pkg::GM_W-1:0];
                endcase
            end
            fsm_pkg::OP_EMIT: begin
                r_out.lap_variance <= r_var;
                r_out.tenengrad    <= r_ten;
                r_out.root_mean    <= r_gm;
            end
            default: begin
            end
        endcase
    end
endmodule

[rtl/fsm_ctrl.sv]
// ----------------------------------------------------------------------------
// fsm_ctrl
// Sequencer: per-pixel steps, then the end-of-region multiply/divide chain.
// ----------------------------------------------------------------------------
module fsm_ctrl #(
    parameter int MUL_STEPS = 44,
    parameter int DIV_STEPS = 88
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output fsm_pkg::t_cmd  o_cmd,
    input  fsm_pkg::t_stat i_stat
);
    localparam int MAXS  = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
    localparam int CNT_W = $clog2(MAXS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_LUMA   = 4'd1;
    localparam logic [3:0] ST_WIN    = 4'd2;
    localparam logic [3:0] ST_CALC   = 4'd3;
    localparam logic [3:0] ST_SQ     = 4'd4;
    localparam logic [3:0] ST_ACC    = 4'd5;
    localparam logic [3:0] ST_SQRT   = 4'd6;
    localparam logic [3:0] ST_ROOT   = 4'd7;
    localparam logic [3:0] ST_MLOAD  = 4'd8;
    localparam logic [3:0] ST_MRUN   = 4'd9;
    localparam logic [3:0] ST_MSTORE = 4'd10;
    localparam logic [3:0] ST_DLOAD  = 4'd11;
    localparam logic [3:0] ST_DRUN   = 4'd12;
    localparam logic [3:0] ST_DSTORE = 4'd13;
    localparam logic [3:0] ST_EMIT   = 4'd14;

    logic [3:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [fsm_pkg::SEL_W-1:0] r_sel, n_sel;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_sel     = r_sel;
        o_cmd.sel = r_sel;
        o_cmd.op  = fsm_pkg::OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = fsm_pkg::OP_ACCEPT;
                    n_state  = ST_LUMA;
                end
            end
            ST_LUMA: begin
                o_cmd.op = fsm_pkg::OP_LUMA;
                n_state  = ST_WIN;
            end
            ST_WIN: begin
                o_cmd.op = fsm_pkg::OP_WIN;
                n_state  = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.op = fsm_pkg::OP_CALC;
                n_state  = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.op = fsm_pkg::OP_SQ;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = fsm_pkg::OP_ACC;
                n_cnt    = '0;
                n_state  = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.op = fsm_pkg::OP_SQRT;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(fsm_pkg::SQ_STEPS - 1)) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                o_cmd.op = fsm_pkg::OP_ROOT;
                if (i_stat.last) begin
                    n_sel   = fsm_pkg::MSEL_N;
                    n_state = ST_MLOAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MLOAD: begin
                o_cmd.op = fsm_pkg::OP_MUL_LOAD;
                n_cnt    = '0;
                n_state  = ST_MRUN;
            end
            ST_MRUN: begin
                o_cmd.op = fsm_pkg::OP_MUL_STEP;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = ST_MSTORE;
                end
            end
            ST_MSTORE: begin
                o_cmd.op = fsm_pkg::OP_MUL_STORE;
                if (r_sel == fsm_pkg::MSEL_P2) begin
                    n_sel   = fsm_pkg::DSEL_VAR;
                    n_state = ST_DLOAD;
                end else begin
                    n_sel   = r_sel + fsm_pkg::SEL_W'(1);
                    n_state = ST_MLOAD;
                end
            end
            ST_DLOAD: begin
                o_cmd.op = fsm_pkg::OP_DIV_LOAD;
                n_cnt    = '0;
                n_state  = ST_DRUN;
            end
            ST_DRUN: begin
                o_cmd.op = fsm_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                o_cmd.op = fsm_pkg::OP_DIV_STORE;
                if (r_sel == fsm_pkg::DSEL_GM) begin
                    n_state = ST_EMIT;
                end else begin
                    n_sel   = r_sel + fsm_pkg::SEL_W'(1);
                    n_state = ST_DLOAD;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = fsm_pkg::OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end
endmodule

[rtl/focus_sharpness_metrics.sv]
// ----------------------------------------------------------------------------
// focus_sharpness_metrics
// Laplacian variance and Sobel gradient focus metrics over a streamed region.
//
//  channel   dir  payload                                  beat
//  i_pix     in   red, green, blue (16 b each)             one pixel, raster
//  o_met     out  lap_variance 36 b, tenengrad 37 b,       one per region
//                 root_mean 19 b
//  i_cfg_*   in   index 0 width, 1 height, 2 color mode    one register write
//
//  Each pixel runs 19 steps in the bit-pair square root unit, and no new pixel
//  is taken until it is done. The last pixel of a region adds four shift-add
//  multiplies of 44 steps and three restoring divides of 88 steps (default sizes).
//  Reset is synchronous; it clears counters, sums and the output valid.
//  A result held on o_met does not block pixel input; only a second result
//  waits until the first has been taken.
// ----------------------------------------------------------------------------
module focus_sharpness_metrics #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fsm_pkg::CFG_W-1:0]       i_cfg_data,
    fsm_stream_if.sink                      i_pix,
    fsm_stream_if.source                    o_met
);
    localparam int NB        = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int MUL_STEPS = fsm_pkg::LAP_W + NB + 1;
    localparam int DIV_STEPS = 2 * MUL_STEPS;

    logic [fsm_pkg::CFG_W-1:0] r_width, r_height;
    logic                      r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= fsm_pkg::RST_WIDTH;
            r_height <= fsm_pkg::RST_HEIGHT;
            r_mode   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fsm_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                fsm_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                fsm_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    fsm_pkg::t_cmd  cmd;
    fsm_pkg::t_stat stat;

    fsm_ctrl #(
        .MUL_STEPS (MUL_STEPS),
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    fsm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_mode      (r_mode),
        .i_pix       (i_pix.payload),
        .o_out_valid (o_met.valid),
        .o_out       (o_met.payload),
        .i_out_ready (o_met.ready)
    );
endmodule

[rtl/fsm_checker.sv]
// ----------------------------------------------------------------------------
// fsm_checker
// Port-level checks of the focus sharpness metrics block, bound to the top.
// ----------------------------------------------------------------------------
module fsm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped before it was taken");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("pixel taken while previous one in progress");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a finishing computation");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid not cleared by reset");
endmodule

bind focus_sharpness_metrics fsm_checker u_fsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_met.valid),
    .i_out_ready (o_met.ready)
);

[verif/focus_sharpness_metrics_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// focus_sharpness_metrics_test
// Streams pixel regions of many sizes and both color modes into the block.
// A scoreboard keeps its own line stores, window and sums, predicts the
// per-region Laplacian variance, tenengrad and gradient mean, and checks
// each metrics beat in order.
// ----------------------------------------------------------------------------
module focus_sharpness_metrics_test;

    localparam int LINE_DEPTH = 4096;
    localparam int SETTLE     = 700;

    class focus_scoreboard;
        bit [fsm_pkg::PIX_W-1:0] upper_row [LINE_DEPTH];
        bit [fsm_pkg::PIX_W-1:0] middle_row [LINE_DEPTH];
        bit [fsm_pkg::PIX_W-1:0] win [9];
        int unsigned    width_reg, height_reg, mode_reg;
        int unsigned    col, row;
        longint         lap_sum;
        longint unsigned lap_sq_sum, grad_sq_sum, grad_root_sum;
        fsm_pkg::t_metrics pending [$];
        int             errors, regions, pixels;

        function new();
            width_reg = 640;
            height_reg = 480;
            mode_reg = 1;
        endfunction

        function void set_reg(logic [fsm_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
            case (idx)
                fsm_pkg::CFG_WIDTH:  width_reg = val;
                fsm_pkg::CFG_HEIGHT: height_reg = val;
                fsm_pkg::CFG_MODE:   mode_reg = val & 1;
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 3) return 3;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function void note(fsm_pkg::t_pixel p);
            int unsigned w, h, x;
            bit [fsm_pkg::PIX_W-1:0] cur, up, mid;
            longint v [9];
            longint lap, gx, gy, mag;
            longint unsigned g2, n;
            logic [127:0] a, b;
            fsm_pkg::t_metrics m;
            w = clamp(width_reg, LINE_DEPTH);
            h = clamp(height_reg, LINE_DEPTH);
            pixels++;
            if (mode_reg != 0)
                cur = 16'((64'(fsm_pkg::W_RED) * p.red + 64'(fsm_pkg::W_GREEN) * p.green
                           + 64'(fsm_pkg::W_BLUE) * p.blue + 64'(fsm_pkg::LUMA_RND)) >> 16);
            else
                cur = p.red;
            x = (col >= LINE_DEPTH) ? LINE_DEPTH - 1 : col;
            up = upper_row[x];
            mid = middle_row[x];
            upper_row[x] = mid;
            middle_row[x] = cur;
            win[0] = win[1]; win[1] = win[2]; win[2] = up;
            win[3] = win[4]; win[4] = win[5]; win[5] = mid;
            win[6] = win[7]; win[7] = win[8]; win[8] = cur;
            if (row >= 2 && col >= 2) begin
                for (int i = 0; i < 9; i++) v[i] = longint'(win[i]);
                lap = 4 * v[4] - v[3] - v[5] - v[1] - v[7];
                gx = (v[2] + 2 * v[5] + v[8]) - (v[0] + 2 * v[3] + v[6]);
                gy = (v[6] + 2 * v[7] + v[8]) - (v[0] + 2 * v[1] + v[2]);
                g2 = gx * gx + gy * gy;
                lap_sum += lap;
                lap_sq_sum += lap * lap;
                grad_sq_sum += g2;
                grad_root_sum += int_root(g2);
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) begin
                    row = 0;
                    n = longint'(w - 2) * longint'(h - 2);
                    mag = (lap_sum < 0) ? -lap_sum : lap_sum;
                    a = 128'(n) * 128'(lap_sq_sum);
                    b = 128'(mag) * 128'(mag);
                    m.lap_variance = (a <= b) ? '0 :
                                     fsm_pkg::VAR_W'((a - b) / (128'(n) * 128'(n)));
                    m.tenengrad = fsm_pkg::TEN_W'(grad_sq_sum / n);
                    m.root_mean = fsm_pkg::GM_W'(grad_root_sum / n);
                    pending.push_back(m);
                    lap_sum = 0;
                    lap_sq_sum = 0;
                    grad_sq_sum = 0;
                    grad_root_sum = 0;
                end
            end
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("MISMATCH region %0d %s: got %0d expected %0d", regions, what, got, want);
            errors++;
        endtask

        task check(fsm_pkg::t_metrics m);
            fsm_pkg::t_metrics e;
            if (pending.size() == 0) begin
                report("unexpected beat", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (m.lap_variance !== e.lap_variance)
                report("lap_variance", m.lap_variance, e.lap_variance);
            if (m.tenengrad !== e.tenengrad) report("tenengrad", m.tenengrad, e.tenengrad);
            if (m.root_mean !== e.root_mean) report("root_mean", m.root_mean, e.root_mean);
            regions++;
        endtask
    endclass

    logic                          i_clk = 0;
    logic                          i_rst_n = 0;
    logic                          cfg_we = 0;
    logic [fsm_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [fsm_pkg::CFG_W-1:0]     cfg_data = '0;
    bit                            calm = 0;
    focus_scoreboard               sb = new();

    fsm_stream_if #(.t_payload(fsm_pkg::t_pixel))   pix_if ();
    fsm_stream_if #(.t_payload(fsm_pkg::t_metrics)) met_if ();

    focus_sharpness_metrics i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_met      (met_if)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        pix_if.valid = 0;
        pix_if.payload = '0;
        met_if.ready = 0;
    end

    always @(negedge i_clk) met_if.ready <= calm || ($urandom_range(99) >= 38);

    always @(posedge i_clk)
        if (i_rst_n && met_if.valid && met_if.ready) sb.check(met_if.payload);

    initial begin
        #100ms;
        $display("focus_sharpness_metrics_test: done, errors");
        $finish;
    end

    task drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_reg(logic [fsm_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        cfg_we = 1;
        cfg_idx = idx;
        cfg_data = fsm_pkg::CFG_W'(val);
        sb.set_reg(idx, val & 16'h1fff);
        @(negedge i_clk);
        cfg_we = 0;
    endtask

    task set_region(int unsigned w, int unsigned h, int unsigned mode);
        drain();
        write_reg(fsm_pkg::CFG_WIDTH, w);
        write_reg(fsm_pkg::CFG_HEIGHT, h);
        write_reg(fsm_pkg::CFG_MODE, mode);
    endtask

    task send_pixel(fsm_pkg::t_pixel p);
        while (!calm && $urandom_range(99) < 38) begin
            pix_if.valid = 0;
            @(negedge i_clk);
        end
        pix_if.valid = 1;
        pix_if.payload = p;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.note(p);
        @(negedge i_clk);
        pix_if.valid = 0;
    endtask

    function fsm_pkg::t_pixel rand_pixel(int unsigned kind);
        fsm_pkg::t_pixel p;
        case (kind)
            0: p = {$urandom_range(1) ? 16'hffff : 16'h0, $urandom_range(1) ? 16'hffff : 16'h0,
                    $urandom_range(1) ? 16'hffff : 16'h0};
            1: p = {16'($urandom_range(2000) + 30000), 16'($urandom_range(2000) + 30000),
                    16'($urandom_range(2000) + 30000)};
            default: p = {16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
        return p;
    endfunction

    task run_region(int unsigned kind);
        int unsigned total;
        total = sb.clamp(sb.width_reg, LINE_DEPTH) * sb.clamp(sb.height_reg, LINE_DEPTH);
        for (int i = 0; i < total; i++) send_pixel(rand_pixel(kind));
    endtask

    initial begin
        int unsigned start;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        calm = 1;
        // directed: single channel extremes, then luma extremes at a saturated and at the minimum size
        set_region(3, 3, 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? {16'hffff, 16'h0, 16'h0} : {16'h0, 16'hffff, 16'hffff});
        set_region(1, 0, 1);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? {16'hffff, 16'hffff, 16'hffff} : fsm_pkg::t_pixel'('0));
        set_region(3, 3, 1);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? fsm_pkg::t_pixel'('0) : {16'hffff, 16'hffff, 16'hffff});
        calm = 0;
        // random regions; a calm stretch in the middle
        start = sb.pixels;
        while (sb.pixels - start < 860) begin
            calm = (sb.pixels - start >= 300 && sb.pixels - start < 450);
            set_region($urandom_range(12, 3), $urandom_range(8, 3), $urandom_range(1));
            repeat ($urandom_range(3, 1)) run_region($urandom_range(3));
        end
        calm = 0;
        pix_if.valid = 0;
        drain();
        $display("covered %0d pixels over %0d regions, both color modes", sb.pixels, sb.regions);
        $display("sizes from the saturated minimum up to twelve by eight");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("focus_sharpness_metrics_test: done, clean");
        else
            $display("focus_sharpness_metrics_test: done, errors");
        $finish;
    end
endmodule
